// ===== rtl/core/message_framer_with_fletcher_checksum_core_macros.svh =====
// Assertion helpers for the framer RTL.
`ifndef MESSAGE_FRAMER_WITH_FLETCHER_CHECKSUM_CORE_MACROS_SVH
`define MESSAGE_FRAMER_WITH_FLETCHER_CHECKSUM_CORE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define MFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfc assertion failed");

// Next-cycle implication, masked during reset.
`define MFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfc assertion failed");

`endif

// ===== rtl/core/mfc_pkg.sv =====
package mfc_pkg;

  // input function codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_DATA  = 2'd1;
  localparam logic [1:0] FUNC_END   = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_START_BYTE = 2'd0;
  localparam logic [1:0] REG_AIRCRAFT   = 2'd1;
  localparam logic [1:0] REG_LEN_OVH    = 2'd2;

  localparam logic [7:0] START_BYTE_RST = 8'd153;
  localparam logic [7:0] AIRCRAFT_RST   = 8'd1;
  localparam logic [7:0] LEN_OVH_RST    = 8'd8;

  localparam logic [7:0] LEN_EXTRA      = 8'd2;
  localparam logic [2:0] MAX_WORD_BYTES = 3'd4;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    OP_START,
    OP_DATA,
    OP_END
  } cmd_op_t;

  // one classified item: up to eight bytes, lowest first
  typedef struct packed {
    cmd_op_t     op;
    logic [2:0]  last_idx;
    logic [63:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] aircraft_id;
    logic [7:0] length_overhead;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/core/message_framer_with_fletcher_checksum_core.sv =====
// Downlink frame builder with a Fletcher-16 style checksum. Each accepted
// input beat is a request: func 0 starts a frame (start byte, length byte =
// payload_length + 2 + length_overhead mod 256, time stamp LSB first,
// aircraft id, message id; 8 output beats), func 1 sends the low
// byte_count bytes of data_word (1..4 beats, counts above 4 act as 4, zero
// sends nothing), func 2 closes the frame with sum A then sum B (2 beats,
// frame_done on sum B). func 3 is ignored. run_last marks the last beat of
// each request. Output runs at one byte per clock while out_stall is low;
// that byte-wide output register is the limit, and queued requests follow
// each other with no gap. Requests are classified in the front end and
// held in a QUEUE_DEPTH-entry queue, so input keeps flowing while the
// output is stalled until the queue fills. Sums are cleared only by reset
// and by a start request. Config registers (bytes 0x0, 0x4, 0x8: start
// byte, aircraft id, length overhead) are to be written only while the
// block is idle. No clearing pass after reset.
`include "message_framer_with_fletcher_checksum_core_macros.svh"

module message_framer_with_fletcher_checksum_core #(
  parameter int QUEUE_DEPTH = mfc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_message_id,
  input  logic [7:0]  in_payload_length,
  input  logic [31:0] in_time_stamp,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  // byte channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_frame_done
);
  import mfc_pkg::*;

  cfg_t    cfg;
  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    head;
  logic    q_push;
  logic    q_pop;

  assign pready = 1'b1;

  // config registers, live values feed the front end
  mfc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // front end: accept, classify, build the byte list for each request
  mfc_front u_front (
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_message_id     (in_message_id),
    .in_payload_length (in_payload_length),
    .in_time_stamp     (in_time_stamp),
    .in_data_word      (in_data_word),
    .in_byte_count     (in_byte_count),
    .cfg               (cfg),
    .q_stat            (q_stat),
    .push              (q_push),
    .push_cmd          (push_cmd)
  );

  // decoupling queue between classification and byte emission
  mfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // back end: one byte per beat, running sums, registered output
  mfc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_frame_done (out_frame_done)
  );

  // frame_done only ever lands on the closing beat of an end request
  `MFC_ASSERT_IMPL(a_done_is_last, clk, rst_n, out_valid && out_frame_done, out_run_last)
  // front end never writes a full queue
  `MFC_ASSERT_IMPL(a_no_overflow, clk, rst_n, q_push, !q_stat.full)
  // back end only retires a request that is present
  `MFC_ASSERT_IMPL(a_no_underflow, clk, rst_n, q_pop, !q_stat.empty)

endmodule

// ===== rtl/core/mfc_regs.sv =====
module mfc_regs (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output mfc_pkg::cfg_t   cfg
);
  import mfc_pkg::*;

  cfg_t cfg_r;
  logic wr_en;
  logic [1:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte      <= START_BYTE_RST;
      cfg_r.aircraft_id     <= AIRCRAFT_RST;
      cfg_r.length_overhead <= LEN_OVH_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_START_BYTE: cfg_r.start_byte      <= pwdata[7:0];
        REG_AIRCRAFT:   cfg_r.aircraft_id     <= pwdata[7:0];
        REG_LEN_OVH:    cfg_r.length_overhead <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_BYTE: prdata = {24'd0, cfg_r.start_byte};
      REG_AIRCRAFT:   prdata = {24'd0, cfg_r.aircraft_id};
      REG_LEN_OVH:    prdata = {24'd0, cfg_r.length_overhead};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/mfc_front.sv =====
module mfc_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_func,
  input  logic [7:0]      in_message_id,
  input  logic [7:0]      in_payload_length,
  input  logic [31:0]     in_time_stamp,
  input  logic [31:0]     in_data_word,
  input  logic [2:0]      in_byte_count,
  input  mfc_pkg::cfg_t   cfg,
  input  mfc_pkg::q_stat_t q_stat,
  output logic            push,
  output mfc_pkg::cmd_t   push_cmd
);
  import mfc_pkg::*;

  logic       accept;
  logic       has_bytes;
  logic [2:0] bc_sat;
  logic [7:0] len_byte;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign bc_sat   = (in_byte_count > MAX_WORD_BYTES) ? MAX_WORD_BYTES : in_byte_count;
  assign len_byte = in_payload_length + LEN_EXTRA + cfg.length_overhead;

  // items that emit nothing (unused code, empty payload) never enter the queue
  always_comb begin
    has_bytes = 1'b0;
    push_cmd  = '{op: OP_DATA, last_idx: 3'd0, data: 64'd0};
    unique case (in_func)
      FUNC_START: begin
        has_bytes = 1'b1;
        push_cmd  = '{op: OP_START, last_idx: 3'd7,
                      data: {in_message_id, cfg.aircraft_id, in_time_stamp,
                             len_byte, cfg.start_byte}};
      end
      FUNC_DATA: begin
        has_bytes = (bc_sat != 3'd0);
        push_cmd  = '{op: OP_DATA, last_idx: bc_sat - 3'd1,
                      data: {32'd0, in_data_word}};
      end
      FUNC_END: begin
        has_bytes = 1'b1;
        push_cmd  = '{op: OP_END, last_idx: 3'd1, data: 64'd0};
      end
      default: ;
    endcase
  end

  assign push = accept && has_bytes;

endmodule

// ===== rtl/core/mfc_queue.sv =====
module mfc_queue #(
  parameter int DEPTH = mfc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mfc_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output mfc_pkg::cmd_t    head,
  output mfc_pkg::q_stat_t q_stat
);
  import mfc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);

endmodule

// ===== rtl/core/mfc_back.sv =====
module mfc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  mfc_pkg::cmd_t    head,
  input  mfc_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_run_last,
  output logic             out_frame_done
);
  import mfc_pkg::*;

  logic [2:0] idx_r;
  logic [7:0] sum_a_r;
  logic [7:0] sum_b_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_run_last_r;
  logic       out_frame_done_r;

  logic       adv;
  logic       take;
  logic       last;
  logic [7:0] cur_byte;
  logic [7:0] sum_a_nxt;
  logic [7:0] sum_b_nxt;

  assign adv  = !out_valid_r || !out_stall;
  assign take = adv && !q_stat.empty;
  assign last = (idx_r == head.last_idx);
  assign pop  = take && last;

  always_comb begin
    if (head.op == OP_END) begin
      cur_byte = (idx_r == 3'd0) ? sum_a_r : sum_b_r;
    end else begin
      cur_byte = head.data[{idx_r, 3'b000} +: 8];
    end
  end

  // Fletcher running sums; start marker clears, checksum bytes are not summed
  always_comb begin
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    if (head.op == OP_START && idx_r == 3'd0) begin
      sum_a_nxt = 8'd0;
      sum_b_nxt = 8'd0;
    end else if (head.op != OP_END) begin
      sum_a_nxt = sum_a_r + cur_byte;
      sum_b_nxt = sum_b_r + sum_a_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      sum_a_r     <= 8'd0;
      sum_b_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else if (take) begin
      idx_r       <= last ? 3'd0 : idx_r + 3'd1;
      sum_a_r     <= sum_a_nxt;
      sum_b_r     <= sum_b_nxt;
      out_valid_r <= 1'b1;
    end else if (adv) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte_r       <= cur_byte;
      out_run_last_r   <= last;
      out_frame_done_r <= (head.op == OP_END) && last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_run_last   = out_run_last_r;
  assign out_frame_done = out_frame_done_r;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mfc_pkg::*;

  // func code 3 has no meaning; the framer must drop it silently
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // idle cycles allowed after the last byte before touching registers
  localparam int SETTLE_CYCLES = 20;

  // one request beat as presented on the input channel
  typedef struct {
    logic [1:0]  func;
    logic [7:0]  msg_id;
    logic [7:0]  pay_len;
    logic [31:0] stamp;
    logic [31:0] word;
    logic [2:0]  count;
  } req_t;

  // one byte beat as expected on the output channel
  typedef struct packed {
    logic [7:0] value;
    logic       run_last;
    logic       frame_done;
  } frame_byte_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // register port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  // request channel
  logic        in_valid = 1'b0;
  wire         in_stall;
  logic [1:0]  in_func = FUNC_START;
  logic [7:0]  in_message_id = '0;
  logic [7:0]  in_payload_length = '0;
  logic [31:0] in_time_stamp = '0;
  logic [31:0] in_data_word = '0;
  logic [2:0]  in_byte_count = '0;

  // byte channel
  wire         out_valid;
  logic        out_stall = 1'b0;
  wire  [7:0]  out_byte;
  wire         out_run_last;
  wire         out_frame_done;

  // local copy of the framer's registers and running sums
  logic [7:0] cur_start_byte = START_BYTE_RST;
  logic [7:0] cur_aircraft   = AIRCRAFT_RST;
  logic [7:0] cur_len_ovh    = LEN_OVH_RST;
  logic [7:0] run_sum_a      = '0;
  logic [7:0] run_sum_b      = '0;

  // bytes still owed by the framer, oldest first
  frame_byte_t pending_bytes[$];

  // idle rates in percent, changed per traffic mix
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // bookkeeping for the run summary
  int mismatches       = 0;
  int items_sent       = 0;
  int bytes_checked    = 0;
  int frames_closed    = 0;
  int settings_applied = 0;

  message_framer_with_fletcher_checksum_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_message_id     (in_message_id),
    .in_payload_length (in_payload_length),
    .in_time_stamp     (in_time_stamp),
    .in_data_word      (in_data_word),
    .in_byte_count     (in_byte_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_run_last      (out_run_last),
    .out_frame_done    (out_frame_done)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the framer hangs
  initial begin
    #3ms;
    $display("FAILURE");
    $finish;
  end

  // only the first ten mismatches get printed, the rest are just counted
  function automatic void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  // adds one byte into the Fletcher sums and returns it as a plain beat
  function automatic frame_byte_t summed_byte(logic [7:0] b);
    frame_byte_t fb;
    run_sum_a = run_sum_a + b;
    run_sum_b = run_sum_b + run_sum_a;
    fb = '{b, 1'b0, 1'b0};
    return fb;
  endfunction

  // works out the byte beats one request causes and queues them
  task automatic predict_stream_bytes(input req_t r);
    frame_byte_t run[$];
    frame_byte_t fb;
    int cnt;
    case (r.func)
      FUNC_START: begin
        // start byte goes out before the sums are cleared, never summed
        fb = '{cur_start_byte, 1'b0, 1'b0};
        run.push_back(fb);
        run_sum_a = '0;
        run_sum_b = '0;
        // length byte wraps mod 256
        run.push_back(summed_byte(r.pay_len + LEN_EXTRA + cur_len_ovh));
        for (int i = 0; i < 4; i++) run.push_back(summed_byte(r.stamp[8*i +: 8]));
        run.push_back(summed_byte(cur_aircraft));
        run.push_back(summed_byte(r.msg_id));
      end
      FUNC_DATA: begin
        // counts above four saturate, zero sends nothing
        cnt = int'((r.count > MAX_WORD_BYTES) ? MAX_WORD_BYTES : r.count);
        for (int i = 0; i < cnt; i++) run.push_back(summed_byte(r.word[8*i +: 8]));
      end
      FUNC_END: begin
        // checksum bytes are not folded back into the sums
        fb = '{run_sum_a, 1'b0, 1'b0};
        run.push_back(fb);
        fb = '{run_sum_b, 1'b0, 1'b1};
        run.push_back(fb);
      end
      default: ;
    endcase
    if (run.size() > 0) run[run.size()-1].run_last = 1'b1;
    foreach (run[i]) pending_bytes.push_back(run[i]);
  endtask

  function automatic req_t make_req(logic [1:0] func, logic [7:0] msg_id,
                                    logic [7:0] pay_len, logic [31:0] stamp,
                                    logic [31:0] word, logic [2:0] count);
    req_t r;
    r.func    = func;
    r.msg_id  = msg_id;
    r.pay_len = pay_len;
    r.stamp   = stamp;
    r.word    = word;
    r.count   = count;
    return r;
  endfunction

  // Presents one request and returns at the edge that takes it. Valid is left
  // high so back-to-back requests need no extra assignment in the same step.
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    predict_stream_bytes(r);
    in_valid          <= 1'b1;
    in_func           <= r.func;
    in_message_id     <= r.msg_id;
    in_payload_length <= r.pay_len;
    in_time_stamp     <= r.stamp;
    in_data_word      <= r.word;
    in_byte_count     <= r.count;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // drop valid, wait for every owed byte, then let the pipe drain of
  // requests that produce nothing
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one setup plus one access phase, then an idle step with psel low before
  // the next access; pready is honored though always high
  task automatic apb_access(input logic write, input logic [1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(input logic [1:0] idx, input logic [7:0] want);
    logic [31:0] got;
    apb_access(1'b0, idx, '0, got);
    if (got[7:0] !== want)
      report_mismatch($sformatf("register %0d read back %02h, expected %02h",
                                idx, got[7:0], want));
  endtask

  task automatic program_register(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] unused;
    apb_access(1'b1, idx, value, unused);
    case (idx)
      REG_START_BYTE: cur_start_byte = value[7:0];
      REG_AIRCRAFT:   cur_aircraft   = value[7:0];
      REG_LEN_OVH:    cur_len_ovh    = value[7:0];
      default: ;
    endcase
    check_register(idx, value[7:0]);
  endtask

  task automatic apply_setting(input logic [31:0] sb, input logic [31:0] ac,
                               input logic [31:0] ovh);
    program_register(REG_START_BYTE, sb);
    program_register(REG_AIRCRAFT, ac);
    program_register(REG_LEN_OVH, ovh);
    settings_applied++;
  endtask

  // Byte checker: every beat taken on the output is matched against the
  // oldest owed byte, field by field.
  always @(posedge clk) begin : byte_check
    frame_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %02h arrived with nothing owed", out_byte));
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (out_frame_done) frames_closed++;
        if (out_byte !== want.value)
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.value));
        if (out_run_last !== want.run_last)
          report_mismatch($sformatf("out_run_last %b, expected %b (byte %02h)",
                                    out_run_last, want.run_last, want.value));
        if (out_frame_done !== want.frame_done)
          report_mismatch($sformatf("out_frame_done %b, expected %b (byte %02h)",
                                    out_frame_done, want.frame_done, want.value));
      end
    end
  end

  // Receiver side stall, rate set per traffic mix.
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  // Reset values readable, a close before any open gives zero sums, then a
  // plain frame under the reset register values.
  task automatic test_power_on_state();
    check_register(REG_START_BYTE, START_BYTE_RST);
    check_register(REG_AIRCRAFT, AIRCRAFT_RST);
    check_register(REG_LEN_OVH, LEN_OVH_RST);
    send_request(make_req(FUNC_END, '0, '0, '0, '0, '0));
    send_request(make_req(FUNC_START, 8'h3c, 8'd4, 32'h0102_0304, '0, '0));
    send_request(make_req(FUNC_DATA, '0, '0, '0, 32'hdead_beef, 3'd4));
    send_request(make_req(FUNC_END, '0, '0, '0, '0, '0));
    settle_block();
  endtask

  // Field extremes, every byte count including zero and the saturating
  // ones, the ignored func code, length wrap and closes without an open.
  task automatic test_field_extremes();
    send_request(make_req(FUNC_START, 8'h00, 8'd0, 32'h0000_0000, '0, '0));
    send_request(make_req(FUNC_DATA, '0, '0, '0, 32'h0000_0000, 3'd1));
    send_request(make_req(FUNC_DATA, '0, '0, '0, 32'hffff_ffff, 3'd4));
    send_request(make_req(FUNC_DATA, '0, '0, '0, 32'ha5c3_5a3c, 3'd2));
    send_request(make_req(FUNC_DATA, '0, '0, '0, 32'h1234_5678, 3'd3));
    send_request(make_req(FUNC_DATA, '0, '0, '0, 32'hffff_ffff, 3'd0));
    send_request(make_req(FUNC_DATA, '0, '0, '0, 32'h89ab_cdef, 3'd5));
    send_request(make_req(FUNC_DATA, '0, '0, '0, 32'h0f1e_2d3c, 3'd6));
    send_request(make_req(FUNC_DATA, '0, '0, '0, 32'hfedc_ba98, 3'd7));
    send_request(make_req(FUNC_UNUSED, 8'hff, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 3'd7));
    send_request(make_req(FUNC_END, '0, '0, '0, '0, '0));
    // 253 + 2 + 8 wraps past 255
    send_request(make_req(FUNC_START, 8'hff, 8'd253, 32'hffff_ffff, '0, '0));
    send_request(make_req(FUNC_START, 8'h80, 8'd255, 32'h8000_0001, 32'hffff_ffff, 3'd7));
    send_request(make_req(FUNC_DATA, '0, '0, '0, 32'hffff_ffff, 3'd7));
    send_request(make_req(FUNC_END, 8'hff, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 3'd7));
    // second close reuses the same sums
    send_request(make_req(FUNC_END, '0, '0, '0, '0, '0));
    settle_block();
  endtask

  // Register extremes and one random setting, each with a short frame.
  task automatic test_register_sweep();
    logic [31:0] sb [3];
    logic [31:0] ac [3];
    logic [31:0] ovh [3];
    sb  = '{32'h0, 32'hffff_ffff, $urandom};
    ac  = '{32'h0, 32'hffff_ffff, $urandom};
    ovh = '{32'h0, 32'hffff_ffff, $urandom};
    for (int i = 0; i < 3; i++) begin
      apply_setting(sb[i], ac[i], ovh[i]);
      send_request(make_req(FUNC_START, 8'($urandom), 8'd253, $urandom, '0, '0));
      send_request(make_req(FUNC_DATA, '0, '0, '0, $urandom, 3'($urandom_range(1, 4))));
      send_request(make_req(FUNC_END, '0, '0, '0, '0, '0));
      settle_block();
    end
  endtask

  // Mostly well-formed frames with random content, some stray requests and
  // some frames left unclosed. Halfway through the sender holds off until
  // the framer has caught up completely.
  task automatic test_random_traffic(input int target, input int send_pct,
                                     input int recv_pct);
    int first;
    int words;
    int pick;
    logic held;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    apply_setting($urandom, $urandom, $urandom);
    first = items_sent;
    held = 1'b0;
    while (items_sent - first < target) begin
      if (!held && (items_sent - first >= target / 2)) begin
        settle_block();
        held = 1'b1;
      end
      pick = int'($urandom_range(99));
      if (pick < 10) begin
        send_request(make_req(2'($urandom_range(3)), 8'($urandom), 8'($urandom),
                              $urandom, $urandom, 3'($urandom)));
      end else begin
        send_request(make_req(FUNC_START, 8'($urandom), 8'($urandom), $urandom,
                              $urandom, 3'($urandom)));
        words = int'($urandom_range(1, 6));
        repeat (words) begin
          send_request(make_req(FUNC_DATA, 8'($urandom), 8'($urandom), $urandom,
                                $urandom,
                                3'(($urandom_range(9) == 0) ? $urandom_range(7)
                                                            : $urandom_range(1, 4))));
        end
        // a few frames are never closed
        if (pick >= 14) send_request(make_req(FUNC_END, 8'($urandom), 8'($urandom),
                                              $urandom, $urandom, 3'($urandom)));
      end
    end
    settle_block();
  endtask

  initial begin
    // synchronous reset asserted from time zero, then released
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_on_state();
    test_field_extremes();
    test_register_sweep();
    test_random_traffic(107, 11, 75);
    test_random_traffic(107, 75, 11);
    test_random_traffic(107, 0, 0);

    $display("run covered %0d requests, %0d bytes checked, %0d frames closed",
             items_sent, bytes_checked, frames_closed);
    $display("across %0d register settings and three stall mixes, %0d mismatches",
             settings_applied, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
